>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl core files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert a property on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// assert a property on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> rtl/core/rgst_pkg.sv
`timescale 1ns / 1ps
// package for the range gcd segment tree block
// types and fixed widths shared by the core modules; no dependencies
package rgst_pkg;
  localparam int ValW = 31;
  localparam int IdxW = 11;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  typedef logic [ValW-1:0] val_t;
  typedef logic [IdxW-1:0] idx_t;
  // handshake between sequencer and gcd unit
  typedef struct packed {
    logic start;
    val_t a;
    val_t b;
  } gcd_req_t;
  typedef struct packed {
    logic busy;
    logic done;
    val_t g;
  } gcd_rsp_t;
endpackage

>>> rtl/core/rgst_gcd_unit.sv
`timescale 1ns / 1ps
// iterative binary gcd unit, one subtract or shift step per cycle
// depends on rgst_pkg and assert_macros.svh
`include "assert_macros.svh"
module rgst_gcd_unit (
  input  logic              clk,
  input  logic              rst,
  input  rgst_pkg::gcd_req_t req,
  output rgst_pkg::gcd_rsp_t rsp
);
  import rgst_pkg::*;
  localparam int ShW = 5;
  val_t a, b;
  logic [ShW-1:0] sh;
  logic busy;
  logic done;
  val_t g;
  val_t diff;
  logic a_gt;

  // compare and subtract of the two operands
  assign a_gt = a > b;
  assign diff = a_gt ? (a - b) : (b - a);

  // step sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        if (req.a == '0 || req.b == '0) begin
          g    <= req.a | req.b;
          done <= 1'b1;
        end else begin
          a    <= req.a;
          b    <= req.b;
          sh   <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (a == b) begin
          g    <= val_t'(a << sh);
          busy <= 1'b0;
          done <= 1'b1;
        end else if (!a[0] && !b[0]) begin
          a  <= a >> 1;
          b  <= b >> 1;
          sh <= sh + 1'b1;
        end else if (!a[0]) begin
          a <= a >> 1;
        end else if (!b[0]) begin
          b <= b >> 1;
        end else if (a_gt) begin
          a <= diff;
        end else begin
          b <= diff;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.g    = g;

  `ASSERT_CLK(a_done_pulse, clk, rst, done |=> !done || $past(req.start), "done held")
  `ASSERT_CLK(a_nonzero, clk, rst, busy |-> (a != '0 && b != '0), "zero operand in loop")
  `ASSERT_CLK(a_end, clk, rst, (busy && a == b) |=> (done && !busy), "no finish")
endmodule

>>> rtl/core/range_gcd_segment_tree_unit.sv
`timescale 1ns / 1ps
// top level of the range gcd segment tree block
// depends on rgst_pkg, rgst_gcd_unit and assert_macros.svh
//
// Usage: requests arrive on s_axis; a write request (op 0) stores slot_value
// at slot_index and rebuilds the gcd along the path to the root, with no
// response. A query request (op 1) returns gcd of slots range_left..range_right
// on m_axis, 0 for an empty range. Out-of-range writes are dropped, query
// bounds are clamped to 1..SIZE.
// One request is handled at a time; s_axis_tready is high only when idle.
// A gcd run in the shared binary gcd unit gives the other operand directly
// when an operand is zero, else runs subtract and shift steps until they match.
// A write rebuilds each level on the path to the root by reading both
// children, running a gcd and writing the parent. A query visits up to
// 2 * log2(SIZE) nodes, running a gcd for each.
// After reset a clearing pass writes zero to all 2*SIZE nodes, one per cycle;
// no request is accepted until the clearing pass ends.
// The result sits in an output register; if the receiver stalls, the block
// still accepts the next request, and waits only before giving a new result.
`include "assert_macros.svh"
module range_gcd_segment_tree_unit #(
  parameter int SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tuser: op
  input  logic        s_axis_tuser,
  // tdata: slot_index[10:0], slot_value[41:11], range_left[52:42],
  // range_right[63:53]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: gcd_result[30:0]
  output logic [31:0] m_axis_tdata
);
  import rgst_pkg::*;
  localparam int AW = $clog2(2*SIZE);
  localparam int SW = $clog2(SIZE+1);
  localparam logic [AW:0] Depth = (AW+1)'(2*SIZE);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WLEAF, S_WRD, S_WRD2, S_WGCD, S_WWAIT,
    S_QCHK, S_QRD, S_QGCD, S_QWAIT, S_QOUT
  } state_t;

  state_t state;
  val_t mem [0:2*SIZE-1];
  val_t rdata;
  logic [AW-1:0] raddr;
  logic we;
  logic [AW-1:0] waddr;
  val_t wdata;

  logic op;
  idx_t in_slot, in_left, in_right;
  val_t in_val;
  val_t wval;
  logic [AW:0] pos, lo, hi, clr;
  val_t acc, lchild;
  logic qside; // 0 picks lo, 1 picks hi
  val_t res;
  logic res_valid;
  gcd_req_t greq;
  gcd_rsp_t grsp;

  assign op       = s_axis_tuser;
  assign in_slot  = s_axis_tdata[10:0];
  assign in_val   = s_axis_tdata[41:11];
  assign in_left  = s_axis_tdata[52:42];
  assign in_right = s_axis_tdata[63:53];

  // node memory with registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  rgst_gcd_unit u_gcd (.clk(clk), .rst(rst), .req(greq), .rsp(grsp));

  logic [SW:0] lft_c, rgt_c;
  always_comb begin
    lft_c = (in_left == '0) ? (SW+1)'(1) : (SW+1)'(in_left);
    rgt_c = ((SW+1)'(in_right) > (SW+1)'(SIZE)) ? (SW+1)'(SIZE) : (SW+1)'(in_right);
  end

  assign s_axis_tready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      res_valid <= 1'b0;
      we        <= 1'b0;
      greq.start <= 1'b0;
    end else begin
      we         <= 1'b0;
      greq.start <= 1'b0;
      // output register load and release
      if (state == S_QOUT && (!res_valid || m_axis_tready)) res_valid <= 1'b1;
      else if (m_axis_tready) res_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          we    <= 1'b1;
          waddr <= clr[AW-1:0];
          wdata <= '0;
          clr   <= clr + 1'b1;
          if (clr == Depth - 1'b1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (op == OP_WRITE) begin
              if (in_slot != '0 && (SW+1)'(in_slot) <= (SW+1)'(SIZE)) begin
                pos   <= (AW+1)'(SIZE) + (AW+1)'(in_slot) - 1'b1;
                wval  <= in_val;
                state <= S_WLEAF;
              end
            end else begin
              acc <= '0;
              if (rgt_c >= lft_c) begin
                lo    <= (AW+1)'(SIZE) + (AW+1)'(lft_c) - 1'b1;
                hi    <= (AW+1)'(SIZE) + (AW+1)'(rgt_c);
                state <= S_QCHK;
              end else begin
                state <= S_QOUT;
              end
            end
          end
        end
        S_WLEAF: begin
          we    <= 1'b1;
          waddr <= pos[AW-1:0];
          wdata <= wval;
          if (pos <= (AW+1)'(1)) state <= S_IDLE;
          else begin
            pos   <= pos >> 1;
            state <= S_WRD;
          end
        end
        S_WRD: begin
          raddr <= {pos[AW-2:0], 1'b0};
          state <= S_WRD2;
        end
        S_WRD2: begin
          raddr <= {pos[AW-2:0], 1'b1};
          state <= S_WGCD;
        end
        S_WGCD: begin
          lchild <= rdata;
          state  <= S_WWAIT;
        end
        S_WWAIT: begin
          if (!grsp.busy && !grsp.done && !greq.start) begin
            greq.start <= 1'b1;
            greq.a     <= lchild;
            greq.b     <= rdata;
          end else if (grsp.done) begin
            we    <= 1'b1;
            waddr <= pos[AW-1:0];
            wdata <= grsp.g;
            if (pos == (AW+1)'(1)) state <= S_IDLE;
            else begin
              pos   <= pos >> 1;
              state <= S_WRD;
            end
          end
        end
        S_QCHK: begin
          if (lo >= hi) begin
            state <= S_QOUT;
          end else if (lo[0]) begin
            raddr <= lo[AW-1:0];
            lo    <= lo + 1'b1;
            qside <= 1'b0;
            state <= S_QRD;
          end else if (hi[0]) begin
            raddr <= hi[AW-1:0] - 1'b1;
            hi    <= hi - 1'b1;
            qside <= 1'b1;
            state <= S_QRD;
          end else begin
            lo <= lo >> 1;
            hi <= hi >> 1;
          end
        end
        S_QRD: state <= S_QGCD;
        S_QGCD: begin
          greq.start <= 1'b1;
          greq.a     <= acc;
          greq.b     <= rdata;
          state      <= S_QWAIT;
        end
        S_QWAIT: begin
          if (grsp.done) begin
            acc <= grsp.g;
            // after the hi side the level is finished
            if (qside) begin
              lo <= lo >> 1;
              hi <= hi >> 1;
            end
            state <= S_QCHK;
          end
        end
        S_QOUT: begin
          if (!res_valid || m_axis_tready) begin
            res   <= acc;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {1'b0, res};

  `ASSERT_CLK(a_no_accept_clear, clk, rst, (state == S_CLEAR) |-> !s_axis_tready, "ready in clear")
  `ASSERT_CLK(a_out_hold, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "drop")
  `ASSERT_CLK(a_range, clk, rst, (state == S_QWAIT) |-> (lo <= hi), "bounds crossed")
endmodule
